// ----- hw/rtl/cpa_pkg.sv -----
// Package for the contiguous page allocator: sizes, codes, register map,
// controller state type and the command and status structs.
// No dependencies; every other file of the block refers to it by scoped names.
package cpa_pkg;

	localparam int HEAP_PAGES  = 256;
	localparam int STACK_PAGES = 256;

	localparam int PAGE_W  = 8;
	localparam int COUNT_W = 9;
	localparam int BYTES_W = 21;
	localparam int WORD_W  = 32;
	localparam int PADDR_W = 5;
	localparam int REGIDX_W = 3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_NOROOM = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REGION_HEAP  = 1'b0;
	localparam logic REGION_STACK = 1'b1;

	localparam logic [REGIDX_W-1:0] REG_HEAP_PAGE_BYTES  = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_STACK_PAGE_BYTES = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_HEAP_BASE        = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_STACK_BASE       = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_HEAP_PAGES_USED  = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_STACK_PAGES_USED = 3'd5;

	localparam logic [BYTES_W-1:0] RST_PAGE_BYTES = 21'd4096;
	localparam logic [COUNT_W-1:0] RST_PAGES_USED = 9'd256;

	typedef struct packed {
		logic [BYTES_W-1:0] heap_page_bytes;
		logic [BYTES_W-1:0] stack_page_bytes;
		logic [WORD_W-1:0]  heap_base;
		logic [WORD_W-1:0]  stack_base;
		logic [COUNT_W-1:0] heap_pages_used;
		logic [COUNT_W-1:0] stack_pages_used;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic               region;
		logic [WORD_W-1:0]  size_bytes;
		logic [PAGE_W-1:0]  free_first_page;
		logic [COUNT_W-1:0] free_count;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PAGE_W-1:0]  first_page;
		logic [COUNT_W-1:0] page_count;
		logic [WORD_W-1:0]  byte_size;
		logic [WORD_W-1:0]  start_address;
	} rsp_t;

	typedef struct packed {
		logic       clear_step;
		logic       load;
		logic       div_start;
		logic       need_load;
		logic       scan_init;
		logic       scan_step;
		logic       mark_init;
		logic       mark_step;
		logic       free_step;
		logic       mult;
		logic       set_status;
		logic [1:0] status_code;
		logic       res_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_free;
		logic div_done;
		logic need_zero;
		logic need_fits;
		logic scan_end;
		logic scan_hit;
		logic mark_last;
		logic free_end;
		logic rsp_busy;
	} sts_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FREE,
		S_DIVW,
		S_CHECK,
		S_SCAN,
		S_MARKI,
		S_MARK,
		S_MULT,
		S_DONE
	} state_t;

endpackage

// ----- hw/rtl/cpa_req_if.sv -----
// Request channel of the contiguous page allocator: valid, ready and payload.
// Depends on cpa_pkg for field widths.
interface cpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic                        region;
	logic [cpa_pkg::WORD_W-1:0]  size_bytes;
	logic [cpa_pkg::PAGE_W-1:0]  free_first_page;
	logic [cpa_pkg::COUNT_W-1:0] free_count;

	modport source (output valid, operation, region, size_bytes, free_first_page,
		free_count, input ready);
	modport sink (input valid, operation, region, size_bytes, free_first_page,
		free_count, output ready);
endinterface

// ----- hw/rtl/cpa_rsp_if.sv -----
// Response channel of the contiguous page allocator: valid, ready and payload.
// Depends on cpa_pkg for field widths.
interface cpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [cpa_pkg::PAGE_W-1:0]  first_page;
	logic [cpa_pkg::COUNT_W-1:0] page_count;
	logic [cpa_pkg::WORD_W-1:0]  byte_size;
	logic [cpa_pkg::WORD_W-1:0]  start_address;

	modport source (output valid, status, first_page, page_count, byte_size,
		start_address, input ready);
	modport sink (input valid, status, first_page, page_count, byte_size,
		start_address, output ready);
endinterface

// ----- hw/rtl/contiguous_page_allocator.sv -----
// Top level of the contiguous page allocator: ties the register file,
// the controller and the datapath to the request and response channels.
// Depends on cpa_pkg, cpa_req_if, cpa_rsp_if, cpa_regs, cpa_ctrl and cpa_dp.

// The allocator keeps a 256-page map for the heap and one for the stack, one
// bit per page, all pages free after reset. Right after reset it clears both
// maps, one page of each per cycle, and accepts no transaction until that pass
// is done. It works on one transaction at a time. An allocate transaction is
// decoded, goes through the iterative divider that turns the byte size into a
// page count, is checked, scans one map bit per cycle up to the end of the
// first fitting run within the pages in use, marks the run, multiplies and
// loads the result. A zero-page or oversize request stops after the check. A
// free transaction clears one page per cycle. The result sits in an output
// register, so the next transaction is accepted as soon as the controller is
// back in idle even if the sink has not yet taken the previous result.
// Configuration registers are written over the APB-style port and must only
// change while the block is idle.
module contiguous_page_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	cpa_req_if.sink                      req,
	cpa_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [cpa_pkg::WORD_W-1:0]   pwdata,
	output logic [cpa_pkg::WORD_W-1:0]   prdata,
	output logic                         pready
);

	cpa_pkg::cfg_t cfg;
	cpa_pkg::cmd_t cmd;
	cpa_pkg::sts_t sts;
	cpa_pkg::req_t req_data;
	cpa_pkg::rsp_t rsp_data;
	logic          rsp_valid;

	// Request payload gathered into one struct for the datapath.
	assign req_data.operation       = req.operation;
	assign req_data.region          = req.region;
	assign req_data.size_bytes      = req.size_bytes;
	assign req_data.free_first_page = req.free_first_page;
	assign req_data.free_count      = req.free_count;

	assign rsp.valid         = rsp_valid;
	assign rsp.status        = rsp_data.status;
	assign rsp.first_page    = rsp_data.first_page;
	assign rsp.page_count    = rsp_data.page_count;
	assign rsp.byte_size     = rsp_data.byte_size;
	assign rsp.start_address = rsp_data.start_address;

	cpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req_data),
		.rsp       (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hw/rtl/cpa_regs.sv -----
// APB-style configuration register file of the contiguous page allocator.
// Depends on cpa_pkg for the register map and the cfg_t struct.
module cpa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [cpa_pkg::WORD_W-1:0]   pwdata,
	output logic [cpa_pkg::WORD_W-1:0]   prdata,
	output logic                         pready,
	output cpa_pkg::cfg_t                cfg
);

	cpa_pkg::cfg_t                 cfg_q;
	logic [cpa_pkg::REGIDX_W-1:0]  idx;
	logic                          wr;

	assign idx    = paddr[cpa_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_page_bytes  <= cpa_pkg::RST_PAGE_BYTES;
			cfg_q.stack_page_bytes <= cpa_pkg::RST_PAGE_BYTES;
			cfg_q.heap_base        <= '0;
			cfg_q.stack_base       <= '0;
			cfg_q.heap_pages_used  <= cpa_pkg::RST_PAGES_USED;
			cfg_q.stack_pages_used <= cpa_pkg::RST_PAGES_USED;
		end else if (wr) begin
			case (idx)
				cpa_pkg::REG_HEAP_PAGE_BYTES: begin
					cfg_q.heap_page_bytes <= pwdata[cpa_pkg::BYTES_W-1:0];
				end
				cpa_pkg::REG_STACK_PAGE_BYTES: begin
					cfg_q.stack_page_bytes <= pwdata[cpa_pkg::BYTES_W-1:0];
				end
				cpa_pkg::REG_HEAP_BASE: begin
					cfg_q.heap_base <= pwdata;
				end
				cpa_pkg::REG_STACK_BASE: begin
					cfg_q.stack_base <= pwdata;
				end
				cpa_pkg::REG_HEAP_PAGES_USED: begin
					cfg_q.heap_pages_used <= pwdata[cpa_pkg::COUNT_W-1:0];
				end
				cpa_pkg::REG_STACK_PAGES_USED: begin
					cfg_q.stack_pages_used <= pwdata[cpa_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			cpa_pkg::REG_HEAP_PAGE_BYTES:  prdata = 32'(cfg_q.heap_page_bytes);
			cpa_pkg::REG_STACK_PAGE_BYTES: prdata = 32'(cfg_q.stack_page_bytes);
			cpa_pkg::REG_HEAP_BASE:        prdata = cfg_q.heap_base;
			cpa_pkg::REG_STACK_BASE:       prdata = cfg_q.stack_base;
			cpa_pkg::REG_HEAP_PAGES_USED:  prdata = 32'(cfg_q.heap_pages_used);
			cpa_pkg::REG_STACK_PAGES_USED: prdata = 32'(cfg_q.stack_pages_used);
			default:                       prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/cpa_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 32 steps.
// Depends on cpa_pkg for operand widths.
module cpa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cpa_pkg::WORD_W-1:0]   dividend,
	input  logic [cpa_pkg::BYTES_W-1:0]  divisor,
	output logic [cpa_pkg::WORD_W-1:0]   quotient,
	output logic [cpa_pkg::BYTES_W:0]    remainder,
	output logic                         done
);

	logic [cpa_pkg::BYTES_W:0]  rem_q;
	logic [cpa_pkg::WORD_W-1:0] quo_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [cpa_pkg::BYTES_W:0]  rem_sh;
	logic                       ge;

	assign rem_sh    = {rem_q[cpa_pkg::BYTES_W-1:0], quo_q[cpa_pkg::WORD_W-1]};
	assign ge        = rem_sh >= {1'b0, divisor};
	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
			quo_q <= {quo_q[cpa_pkg::WORD_W-2:0], ge};
		end
	end

endmodule

// ----- hw/rtl/cpa_dp.sv -----
// Datapath of the contiguous page allocator: page maps, request registers,
// scan and marking counters, divider, products and the result register.
// Depends on cpa_pkg and cpa_div.
module cpa_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  cpa_pkg::cfg_t cfg,
	input  cpa_pkg::req_t req,
	output cpa_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  cpa_pkg::cmd_t cmd,
	output cpa_pkg::sts_t sts
);

	logic                         heap_mem  [cpa_pkg::HEAP_PAGES];
	logic                         stack_mem [cpa_pkg::STACK_PAGES];
	logic                         map_bit_q;
	logic [cpa_pkg::PAGE_W-1:0]   rd_addr;
	logic [cpa_pkg::PAGE_W-1:0]   clr_idx_q;

	logic                         op_q;
	logic                         region_q;
	logic [cpa_pkg::WORD_W-1:0]   size_q;
	logic [cpa_pkg::BYTES_W-1:0]  bytes_q;
	logic [cpa_pkg::COUNT_W-1:0]  used_q;
	logic [cpa_pkg::WORD_W-1:0]   base_q;

	logic [cpa_pkg::COUNT_W-1:0]  idx_q;
	logic [cpa_pkg::COUNT_W-1:0]  left_q;
	logic [cpa_pkg::COUNT_W-1:0]  run_q;
	logic [cpa_pkg::COUNT_W-1:0]  need_q;
	logic                         need_zero_q;
	logic                         need_fits_q;
	logic [cpa_pkg::PAGE_W-1:0]   start_q;
	logic [1:0]                   status_q;

	logic [cpa_pkg::WORD_W-1:0]   bsize_s1;
	logic [cpa_pkg::WORD_W-1:0]   off_s1;

	cpa_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	logic [cpa_pkg::WORD_W-1:0]   div_q;
	logic [cpa_pkg::BYTES_W:0]    div_r;
	logic                         div_done;
	logic [cpa_pkg::WORD_W:0]     need_wide;
	logic                         cur_bit;
	logic [cpa_pkg::COUNT_W-1:0]  run_inc;
	logic [cpa_pkg::COUNT_W-1:0]  start_calc;
	logic [cpa_pkg::BYTES_W-1:0]  bytes_sel;
	logic [cpa_pkg::COUNT_W-1:0]  used_sel;
	logic                         alloc_ok;

	cpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (size_q),
		.divisor   (bytes_q),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	// A page size of zero counts as one byte; pages in use saturate at the map depth.
	always_comb begin
		if (req.region == cpa_pkg::REGION_STACK) begin
			bytes_sel = cfg.stack_page_bytes;
			used_sel  = (cfg.stack_pages_used > cpa_pkg::COUNT_W'(cpa_pkg::STACK_PAGES)) ?
				cpa_pkg::COUNT_W'(cpa_pkg::STACK_PAGES) : cfg.stack_pages_used;
		end else begin
			bytes_sel = cfg.heap_page_bytes;
			used_sel  = (cfg.heap_pages_used > cpa_pkg::COUNT_W'(cpa_pkg::HEAP_PAGES)) ?
				cpa_pkg::COUNT_W'(cpa_pkg::HEAP_PAGES) : cfg.heap_pages_used;
		end
		if (bytes_sel == '0) begin
			bytes_sel = cpa_pkg::BYTES_W'(1);
		end
	end

	// The map read is registered, so the scan fetches the page it will look at next.
	assign rd_addr    = cmd.scan_init ? '0 : (idx_q[cpa_pkg::PAGE_W-1:0] + 8'd1);
	assign need_wide  = {1'b0, div_q} + {32'd0, (div_r != '0)};
	assign cur_bit    = map_bit_q;
	assign run_inc    = run_q + 9'd1;
	assign start_calc = idx_q + 9'd1 - need_q;
	assign alloc_ok   = (status_q == cpa_pkg::ST_OK) && (op_q == cpa_pkg::OP_ALLOC);

	assign sts.clear_last = &clr_idx_q;
	assign sts.op_free    = (op_q == cpa_pkg::OP_FREE);
	assign sts.div_done   = div_done;
	assign sts.need_zero  = need_zero_q;
	assign sts.need_fits  = need_fits_q;
	assign sts.scan_end   = (idx_q == used_q);
	assign sts.scan_hit   = !cur_bit && (run_inc >= need_q);
	assign sts.mark_last  = (left_q == 9'd1);
	assign sts.free_end   = (left_q == '0) || idx_q[cpa_pkg::COUNT_W-1];
	assign sts.rsp_busy   = rsp_valid_q && !rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// Address of the clearing pass that frees every page after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear_step) begin
			clr_idx_q <= clr_idx_q + 8'd1;
		end
	end

	// Page maps: one bit per page, set when allocated; the clearing pass after
	// reset frees every page.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			heap_mem[clr_idx_q]  <= 1'b0;
			stack_mem[clr_idx_q] <= 1'b0;
		end else if (cmd.mark_step || cmd.free_step) begin
			if (region_q == cpa_pkg::REGION_STACK) begin
				stack_mem[idx_q[cpa_pkg::PAGE_W-1:0]] <= cmd.mark_step;
			end else begin
				heap_mem[idx_q[cpa_pkg::PAGE_W-1:0]] <= cmd.mark_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (region_q == cpa_pkg::REGION_STACK) begin
			map_bit_q <= stack_mem[rd_addr];
		end else begin
			map_bit_q <= heap_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.operation;
			region_q <= req.region;
			size_q   <= req.size_bytes;
			bytes_q  <= bytes_sel;
			used_q   <= used_sel;
			base_q   <= (req.region == cpa_pkg::REGION_STACK) ? cfg.stack_base : cfg.heap_base;
			idx_q    <= {1'b0, req.free_first_page};
			left_q   <= req.free_count;
		end else if (cmd.scan_init) begin
			idx_q <= '0;
			run_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 9'd1;
			run_q <= cur_bit ? '0 : run_inc;
			if (!cur_bit && (run_inc >= need_q)) begin
				start_q <= start_calc[cpa_pkg::PAGE_W-1:0];
			end
		end else if (cmd.mark_init) begin
			idx_q  <= {1'b0, start_q};
			left_q <= need_q;
		end else if (cmd.mark_step || cmd.free_step) begin
			idx_q  <= idx_q + 9'd1;
			left_q <= left_q - 9'd1;
		end
		if (cmd.need_load) begin
			need_q      <= need_wide[cpa_pkg::COUNT_W-1:0];
			need_zero_q <= (need_wide == '0);
			need_fits_q <= (need_wide <= {24'd0, used_q});
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.mult) begin
			bsize_s1 <= 32'(need_q * bytes_q);
			off_s1   <= 32'(start_q * bytes_q);
		end
	end

	// Result register: holds one finished transaction until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.status <= status_q;
			if (alloc_ok) begin
				rsp_q.first_page    <= start_q;
				rsp_q.page_count    <= need_q;
				rsp_q.byte_size     <= bsize_s1;
				rsp_q.start_address <= (region_q == cpa_pkg::REGION_STACK) ?
					(base_q - off_s1) : (base_q + off_s1);
			end else begin
				rsp_q.first_page    <= '0;
				rsp_q.page_count    <= '0;
				rsp_q.byte_size     <= '0;
				rsp_q.start_address <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/cpa_ctrl.sv -----
// Controller state machine of the contiguous page allocator.
// Depends on cpa_pkg for the state type and the command and status structs.
module cpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output cpa_pkg::cmd_t cmd,
	input  cpa_pkg::sts_t sts
);

	cpa_pkg::state_t state_q;
	cpa_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpa_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cpa_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_nx = cpa_pkg::S_IDLE;
				end
			end
			cpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = cpa_pkg::S_DECODE;
				end
			end
			cpa_pkg::S_DECODE: begin
				if (sts.op_free) begin
					state_nx = cpa_pkg::S_FREE;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = cpa_pkg::S_DIVW;
				end
			end
			cpa_pkg::S_FREE: begin
				if (sts.free_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = cpa_pkg::ST_OK;
					state_nx        = cpa_pkg::S_DONE;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			cpa_pkg::S_DIVW: begin
				if (sts.div_done) begin
					cmd.need_load = 1'b1;
					state_nx      = cpa_pkg::S_CHECK;
				end
			end
			cpa_pkg::S_CHECK: begin
				if (sts.need_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = cpa_pkg::ST_ZERO;
					state_nx        = cpa_pkg::S_DONE;
				end else if (!sts.need_fits) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = cpa_pkg::ST_NOROOM;
					state_nx        = cpa_pkg::S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_nx      = cpa_pkg::S_SCAN;
				end
			end
			cpa_pkg::S_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = cpa_pkg::ST_NOROOM;
					state_nx        = cpa_pkg::S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					if (sts.scan_hit) begin
						state_nx = cpa_pkg::S_MARKI;
					end
				end
			end
			cpa_pkg::S_MARKI: begin
				cmd.mark_init = 1'b1;
				state_nx      = cpa_pkg::S_MARK;
			end
			cpa_pkg::S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_last) begin
					state_nx = cpa_pkg::S_MULT;
				end
			end
			cpa_pkg::S_MULT: begin
				cmd.mult        = 1'b1;
				cmd.set_status  = 1'b1;
				cmd.status_code = cpa_pkg::ST_OK;
				state_nx        = cpa_pkg::S_DONE;
			end
			cpa_pkg::S_DONE: begin
				if (!sts.rsp_busy) begin
					cmd.res_load = 1'b1;
					state_nx     = cpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = cpa_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_res_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !sts.rsp_busy)
		else $error("result loaded while the result register is still held");

	a_hit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpa_pkg::S_SCAN) && !sts.scan_end && sts.scan_hit
		|=> state_q == cpa_pkg::S_MARKI)
		else $error("found run did not lead to the marking pass");

	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == cpa_pkg::S_DECODE)
		else $error("accepted transaction was not decoded");

	a_div_before_need: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider reported done right after start");
`endif

endmodule

// ----- tb/contiguous_page_allocator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the contiguous page allocator: APB register access,
// directed first-fit cases and random allocate/free traffic checked against a local model.
// Depends on cpa_pkg, cpa_req_if, cpa_rsp_if and the contiguous_page_allocator RTL.
module contiguous_page_allocator_tb;
	import cpa_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int MAP_SLOTS       = (HEAP_PAGES > STACK_PAGES) ? HEAP_PAGES : STACK_PAGES;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 66;
	// A worst-case allocate scans and marks a full map.
	localparam int TAIL_CYCLES     = 600;
	// The slowest legal run is about 550 worst-case transactions plus the longest
	// sender gap and receiver stall each; the limit lies several times above it.
	localparam int CYCLE_LIMIT     = 1500000;

	// Receiver back-pressure patterns, picked at random by the receiver process.
	typedef enum int {RX_STEADY, RX_CHOPPY, RX_LONG_STALLS} rx_pattern_t;

	// A run of pages handed out by the allocator and not yet given back.
	typedef struct {
		logic               region;
		logic [PAGE_W-1:0]  first;
		logic [COUNT_W-1:0] count;
	} page_run_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [WORD_W-1:0]   pwdata;
	logic [WORD_W-1:0]   prdata;
	logic                pready;

	cpa_req_if req_ch();
	cpa_rsp_if rsp_ch();

	contiguous_page_allocator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Local copy of the register file and of both page maps (1 = page allocated).
	cfg_t        model_cfg;
	bit          page_map [2][MAP_SLOTS];
	// Responses predicted for accepted requests, oldest first.
	rsp_t        expected_responses [$];
	page_run_t   allocated_runs [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          stall_window = 0;
	rx_pattern_t stall_mode = RX_STEADY;

	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want,
				got);
		end
	endfunction

	// Works out the response to one request and applies its effect on the maps.
	// A free clears pages inside the map and always answers ok with zero fields.
	// An allocate converts bytes to pages (rounding up, zero page size counts as one),
	// then looks for the run of free pages that ends lowest within the pages in use.
	function automatic rsp_t predict_allocation(input req_t item);
		rsp_t              res;
		int                r, depth, used, start, run, i, last;
		logic [31:0]       bytes, base, offset;
		longint unsigned   need;
		bit                found;
		res = '0;
		r = (item.region == REGION_STACK) ? 1 : 0;
		depth = r ? STACK_PAGES : HEAP_PAGES;
		bytes = r ? 32'(model_cfg.stack_page_bytes) : 32'(model_cfg.heap_page_bytes);
		base = r ? model_cfg.stack_base : model_cfg.heap_base;
		used = r ? int'(model_cfg.stack_pages_used) : int'(model_cfg.heap_pages_used);
		if (bytes == 0)
			bytes = 1;
		if (used > depth)
			used = depth;
		if (item.operation == OP_FREE) begin
			last = int'(item.free_first_page) + int'(item.free_count);
			for (i = int'(item.free_first_page); i < last; i++)
				if (i < depth)
					page_map[r][i] = 1'b0;
			res.status = ST_OK;
			return res;
		end
		need = item.size_bytes / bytes + (((item.size_bytes % bytes) != 0) ? 1 : 0);
		if (need == 0) begin
			res.status = ST_ZERO;
			return res;
		end
		found = 1'b0;
		run = 0;
		start = 0;
		if (need <= used) begin
			for (i = 0; i < used && !found; i++) begin
				if (!page_map[r][i])
					run++;
				else
					run = 0;
				if (run >= need) begin
					start = i + 1 - int'(need);
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			res.status = ST_NOROOM;
			return res;
		end
		for (i = start; i < start + int'(need); i++)
			page_map[r][i] = 1'b1;
		offset = 32'(start) * bytes;
		res.status = ST_OK;
		res.first_page = start[PAGE_W-1:0];
		res.page_count = need[COUNT_W-1:0];
		res.byte_size = need[31:0] * bytes;
		// The stack grows downward from its base, so its address can wrap below zero.
		res.start_address = r ? base - offset : base + offset;
		return res;
	endfunction

	// Fields that the operation ignores still carry random values.
	function automatic req_t make_alloc(input logic region, input logic [31:0] size);
		req_t item;
		item.operation = OP_ALLOC;
		item.region = region;
		item.size_bytes = size;
		item.free_first_page = PAGE_W'($urandom);
		item.free_count = COUNT_W'($urandom);
		return item;
	endfunction

	function automatic req_t make_free(input logic region, input logic [PAGE_W-1:0] first,
			input logic [COUNT_W-1:0] count);
		req_t item;
		item.operation = OP_FREE;
		item.region = region;
		item.size_bytes = $urandom;
		item.free_first_page = first;
		item.free_count = count;
		return item;
	endfunction

	function automatic logic [31:0] register_value(input logic [REGIDX_W-1:0] idx);
		case (idx)
			REG_HEAP_PAGE_BYTES:  return 32'(model_cfg.heap_page_bytes);
			REG_STACK_PAGE_BYTES: return 32'(model_cfg.stack_page_bytes);
			REG_HEAP_BASE:        return model_cfg.heap_base;
			REG_STACK_BASE:       return model_cfg.stack_base;
			REG_HEAP_PAGES_USED:  return 32'(model_cfg.heap_pages_used);
			REG_STACK_PAGES_USED: return 32'(model_cfg.stack_pages_used);
			default:              return 32'h0;
		endcase
	endfunction

	// One APB transfer: setup cycle, then access cycle held until pready.
	task automatic apb_transfer(input logic is_write, input logic [REGIDX_W-1:0] idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = is_write;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic read_register_check(input logic [REGIDX_W-1:0] idx);
		logic [31:0] got;
		apb_transfer(1'b0, idx, 32'h0, got);
		check_field($sformatf("register %0d readback", idx), register_value(idx), got);
	endtask

	// Writes one register, mirrors it in the local copy and reads it back.
	task automatic write_register(input logic [REGIDX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_transfer(1'b1, idx, value, unused);
		case (idx)
			REG_HEAP_PAGE_BYTES:  model_cfg.heap_page_bytes = value[BYTES_W-1:0];
			REG_STACK_PAGE_BYTES: model_cfg.stack_page_bytes = value[BYTES_W-1:0];
			REG_HEAP_BASE:        model_cfg.heap_base = value;
			REG_STACK_BASE:       model_cfg.stack_base = value;
			REG_HEAP_PAGES_USED:  model_cfg.heap_pages_used = value[COUNT_W-1:0];
			REG_STACK_PAGES_USED: model_cfg.stack_pages_used = value[COUNT_W-1:0];
			default: ;
		endcase
		read_register_check(idx);
	endtask

	// Only called while no transaction is in flight.
	task automatic configure_allocator(input logic [BYTES_W-1:0] heap_bytes,
			input logic [BYTES_W-1:0] stack_bytes, input logic [31:0] heap_addr,
			input logic [31:0] stack_addr, input logic [COUNT_W-1:0] heap_used,
			input logic [COUNT_W-1:0] stack_used);
		write_register(REG_HEAP_PAGE_BYTES, 32'(heap_bytes));
		write_register(REG_STACK_PAGE_BYTES, 32'(stack_bytes));
		write_register(REG_HEAP_BASE, heap_addr);
		write_register(REG_STACK_BASE, stack_addr);
		write_register(REG_HEAP_PAGES_USED, 32'(heap_used));
		write_register(REG_STACK_PAGES_USED, 32'(stack_used));
	endtask

	// Presents one request and waits until it is accepted. Requests go out in bursts
	// of random length; between bursts valid drops for a random gap, sometimes longer
	// than the block needs for a whole transaction.
	task automatic send_request(input req_t item);
		rsp_t predicted;
		int   gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req_ch.operation = item.operation;
		req_ch.region = item.region;
		req_ch.size_bytes = item.size_bytes;
		req_ch.free_first_page = item.free_first_page;
		req_ch.free_count = item.free_count;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_allocation(item);
		expected_responses.push_back(predicted);
		if (item.operation == OP_ALLOC && predicted.status == ST_OK)
			allocated_runs.push_back('{item.region, predicted.first_page, predicted.page_count});
	endtask

	// Drops valid and holds off until every predicted response has been taken.
	task automatic wait_for_results_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Checks that every register comes out of reset with its documented value.
	task automatic test_reset_values();
		for (int i = REG_HEAP_PAGE_BYTES; i <= REG_STACK_PAGES_USED; i++)
			read_register_check(REGIDX_W'(i));
	endtask

	// First-fit placement, rounding of the page count, zero requests, a request far
	// larger than the map, the downward stack address wrapping below zero, frees that
	// run past the end of the map and a free of zero pages.
	task automatic test_first_fit_basics();
		configure_allocator(21'd4096, 21'd4096, 32'h1000_0000, 32'h0000_2000, 9'd256, 9'd256);
		send_request(make_alloc(REGION_HEAP, 32'd0));
		send_request(make_alloc(REGION_HEAP, 32'd1));
		send_request(make_alloc(REGION_HEAP, 32'd4097));
		send_request(make_alloc(REGION_STACK, 32'hFFFF_FFFF));
		send_request(make_alloc(REGION_STACK, 32'd12288));
		send_request(make_alloc(REGION_STACK, 32'd4096));
		// Open a one-page hole at page 1: a two-page request must skip it,
		// a one-page request must land in it.
		send_request(make_free(REGION_HEAP, 8'd1, 9'd1));
		send_request(make_alloc(REGION_HEAP, 32'd8192));
		send_request(make_alloc(REGION_HEAP, 32'd4096));
		send_request(make_free(REGION_HEAP, 8'd255, 9'd256));
		send_request(make_free(REGION_STACK, 8'd0, 9'd0));
		send_request(make_free(REGION_HEAP, 8'd0, 9'd256));
		// The whole heap map as one run, then nothing is left.
		send_request(make_alloc(REGION_HEAP, 32'h0010_0000));
		send_request(make_alloc(REGION_HEAP, 32'd1));
		send_request(make_free(REGION_HEAP, 8'd0, 9'd256));
		wait_for_results_drained();
	endtask

	// Register extremes: zero page size (taken as one byte), large page sizes up to the largest,
	// no pages in use, a pages-in-use value above the map depth, an all-ones heap base.
	task automatic test_register_extremes();
		configure_allocator(21'd0, 21'd1048576, 32'hFFFF_FFFF, 32'h0, 9'd0, 9'h1FF);
		send_request(make_alloc(REGION_HEAP, 32'd1));
		send_request(make_alloc(REGION_STACK, 32'hFFFF_FFFF));
		send_request(make_free(REGION_STACK, 8'd0, 9'd256));
		send_request(make_alloc(REGION_STACK, 32'h0FFF_FFFF));
		send_request(make_free(REGION_STACK, 8'd0, 9'd256));
		wait_for_results_drained();

		configure_allocator(21'h1F_FFFF, 21'd1, 32'hFFFF_FFFF, 32'h0, 9'd1, 9'd256);
		send_request(make_alloc(REGION_HEAP, 32'h001F_FFFF));
		send_request(make_alloc(REGION_HEAP, 32'd1));
		send_request(make_alloc(REGION_STACK, 32'd3));
		send_request(make_alloc(REGION_STACK, 32'd1));
		send_request(make_free(REGION_HEAP, 8'd0, 9'd1));
		send_request(make_free(REGION_STACK, 8'd0, 9'd4));
		wait_for_results_drained();
	endtask

	// Random traffic over several register settings. Most transactions are
	// allocations sized in whole pages of the current setting and frees of runs that
	// were actually handed out, so the maps fragment and fill; the rest are zero
	// requests, raw random sizes and frees at random places.
	task automatic test_random_traffic();
		req_t        item;
		logic        region;
		int          pick, k, eff, used_eff, pages;
		logic [31:0] size;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_results_drained();
			case (phase)
				0: configure_allocator(21'd4096, 21'd4096, $urandom, $urandom, 9'd256, 9'd256);
				1: configure_allocator(21'd1, 21'h1F_FFFF, $urandom, $urandom, 9'd256, 9'd256);
				2: configure_allocator(21'd0, 21'd1048576, $urandom, $urandom, 9'h1FF, 9'd0);
				3: configure_allocator(BYTES_W'($urandom_range(1, 64)),
					BYTES_W'($urandom_range(1, 8192)), 32'h0, 32'hFFFF_FFFF, 9'd16, 9'd64);
				default: configure_allocator(BYTES_W'($urandom_range(1, 21'h1F_FFFF)),
					BYTES_W'($urandom_range(1, 4096)), $urandom, $urandom,
					COUNT_W'($urandom_range(1, 256)), COUNT_W'($urandom_range(1, 256)));
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Once, in the middle of a phase, let the pipeline run completely dry.
				if (phase == 0 && n == ITEMS_PER_PHASE / 2)
					wait_for_results_drained();
				region = 1'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 35 && allocated_runs.size() != 0) begin
					k = $urandom_range(0, allocated_runs.size() - 1);
					item = make_free(allocated_runs[k].region, allocated_runs[k].first,
						allocated_runs[k].count);
					allocated_runs.delete(k);
				end else if (pick < 42) begin
					item = make_free(region, PAGE_W'($urandom), COUNT_W'($urandom));
				end else if (pick < 46) begin
					item = make_alloc(region, 32'd0);
				end else if (pick < 52) begin
					item = make_alloc(region, $urandom);
				end else begin
					eff = (region == REGION_STACK) ? int'(model_cfg.stack_page_bytes) :
						int'(model_cfg.heap_page_bytes);
					used_eff = (region == REGION_STACK) ? int'(model_cfg.stack_pages_used) :
						int'(model_cfg.heap_pages_used);
					if (eff == 0)
						eff = 1;
					if (used_eff > MAP_SLOTS)
						used_eff = MAP_SLOTS;
					if (used_eff == 0)
						used_eff = 1;
					// Mostly short runs, now and then anything up to the pages in use.
					pages = ($urandom_range(0, 9) == 0) ? $urandom_range(1, used_eff) :
						$urandom_range(1, (used_eff < 12) ? used_eff : 12);
					size = 32'((pages - 1) * eff + int'($urandom_range(1, eff)));
					item = make_alloc(region, size);
				end
				send_request(item);
			end
		end
	endtask

	// The receiver switches between taking every response, short frequent stalls
	// and rare long stalls, so stalls land on every stage of the block's work.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			stall_window++;
			if (stall_window % 300 == 0)
				stall_mode = rx_pattern_t'($urandom_range(RX_STEADY, RX_LONG_STALLS));
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				case (stall_mode)
					RX_CHOPPY: begin
						if ($urandom_range(0, 2) == 0)
							stall_left = $urandom_range(1, 3);
					end
					RX_LONG_STALLS: begin
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(4, 20);
					end
					default: ;
				endcase
			end
		end
	end

	// Every response transaction is matched field by field against the oldest
	// prediction; a response with nothing outstanding is an error of its own.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_responses.size() == 0) begin
				error_count++;
				$display("%0t: unexpected response, expected none, actual status %0d page %0d",
					$time, rsp_ch.status, rsp_ch.first_page);
			end else begin
				check_field("status", expected_responses[0].status, rsp_ch.status);
				check_field("first_page", expected_responses[0].first_page, rsp_ch.first_page);
				check_field("page_count", expected_responses[0].page_count, rsp_ch.page_count);
				check_field("byte_size", expected_responses[0].byte_size, rsp_ch.byte_size);
				check_field("start_address", expected_responses[0].start_address,
					rsp_ch.start_address);
				void'(expected_responses.pop_front());
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.region = REGION_HEAP;
		req_ch.size_bytes = '0;
		req_ch.free_first_page = '0;
		req_ch.free_count = '0;
		rsp_ch.ready = 1'b0;
		// Local model starts from the reset state: default registers, all pages free.
		model_cfg.heap_page_bytes = RST_PAGE_BYTES;
		model_cfg.stack_page_bytes = RST_PAGE_BYTES;
		model_cfg.heap_base = '0;
		model_cfg.stack_base = '0;
		model_cfg.heap_pages_used = RST_PAGES_USED;
		model_cfg.stack_pages_used = RST_PAGES_USED;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_first_fit_basics();
		test_register_extremes();
		test_random_traffic();

		wait_for_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_responses.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cpa_pkg.sv
hw/rtl/cpa_req_if.sv
hw/rtl/cpa_rsp_if.sv
hw/rtl/cpa_regs.sv
hw/rtl/cpa_div.sv
hw/rtl/cpa_dp.sv
hw/rtl/cpa_ctrl.sv
hw/rtl/contiguous_page_allocator.sv
tb/contiguous_page_allocator_tb.sv
